@@ src/drp_pkg.sv @@
// Shared types and constants for the DHCP reply parser and client state machine.
package drp_pkg;

    localparam logic [31:0] XID_RESET    = 32'h4B4E_5453;
    localparam logic [31:0] COOKIE_VALUE = 32'h6382_5363;

    localparam logic [7:0] OP_REPLY     = 8'd2;
    localparam logic [7:0] IDX_XID_LO   = 8'd4;
    localparam logic [7:0] IDX_XID_HI   = 8'd7;
    localparam logic [7:0] IDX_YIP_LO   = 8'd16;
    localparam logic [7:0] IDX_YIP_HI   = 8'd19;
    localparam logic [7:0] IDX_MAGIC_LO = 8'd236;
    localparam logic [7:0] IDX_LAST_HDR = 8'd239;
    localparam logic [7:0] IDX_OPTS     = 8'd240;

    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_GATEWAY = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_MTYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER  = 8'd54;
    localparam logic [7:0] OPT_END     = 8'hFF;

    localparam logic [7:0] MT_OFFER = 8'd2;
    localparam logic [7:0] MT_ACK   = 8'd5;
    localparam logic [7:0] MT_NAK   = 8'd6;

    localparam logic [1:0] ADDR_XID = 2'd0;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 176;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } t_opt_phase;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_DISC  = 3'd1,
        ST_REQ   = 3'd2,
        ST_BOUND = 3'd3,
        ST_FAIL  = 3'd4
    } t_client_state;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_DISCOVER = 3'd1,
        ACT_REQUEST  = 3'd2,
        ACT_BOUND    = 3'd3,
        ACT_REJECTED = 3'd4,
        ACT_BINDFAIL = 3'd5
    } t_action;

    // One event handed from the parser to the client machine.
    typedef struct packed {
        logic        is_start;
        logic        bind_failed;
        logic        reply_ok;
        logic [7:0]  mtype;
        logic [31:0] your_ip;
        logic [31:0] server;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
    } t_evt;

endpackage

@@ src/dhcp_reply_parser_client_fsm.sv @@
// DHCP reply parser with client state machine; results pass the event queue, then the result register.
// Throughput: one byte or start request per cycle while the queue is not full; the two-entry
// event queue and the result register let both sides stall on their own.
// Only starts and last bytes give a result; other bytes give none.
// Synchronous active-low reset: state INIT, parser cleared, stores zero, xid 0x4B4E5453.
module dhcp_reply_parser_client_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [drp_pkg::IN_DATA_W-1:0]   i_s_tdata,  // port_bind_failed, payload_byte[8:1]
    input  logic                            i_s_tuser,  // opcode
    input  logic                            i_s_tlast,  // last_byte
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // action[2:0], client_state[5:3], message_type[13:6], assigned_ip[45:14],
    // server_ident[77:46], netmask[109:78], gateway[141:110], name_server[173:142]
    output logic [drp_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import drp_pkg::*;

    logic [31:0] r_xid;
    logic        accept;
    logic        push, pop, full, nonempty;
    t_evt        evt_in, evt_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_XID) ? r_xid : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_xid <= XID_RESET;
        else if (psel && penable && pwrite)
            r_xid <= pwdata;
    end

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    drp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_xid         (r_xid),
        .i_accept      (accept),
        .i_opcode      (i_s_tuser),
        .i_bind_failed (i_s_tdata[0]),
        .i_byte        (i_s_tdata[8:1]),
        .i_last        (i_s_tlast),
        .o_push        (push),
        .o_evt         (evt_in)
    );

    drp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_evt      (evt_in),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_evt      (evt_out)
    );

    drp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (nonempty),
        .i_evt       (evt_out),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata)
    );

endmodule

@@ src/drp_front.sv @@
// Byte parser: header checks, option walk, value capture, event generation.
module drp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_xid,
    input  logic          i_accept,
    input  logic          i_opcode,
    input  logic          i_bind_failed,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output drp_pkg::t_evt o_evt
);
    import drp_pkg::*;

    logic [7:0]  r_offset, n_offset;
    logic        r_hgood, n_hgood;
    logic [31:0] r_xid, n_xid;
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_yip, n_yip;
    t_opt_phase  r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_len, n_len;
    logic [31:0] r_vbuf, n_vbuf;
    logic [7:0]  r_seen, n_seen;
    logic [31:0] r_server, n_server;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_router, n_router;
    logic [31:0] r_dns, n_dns;

    logic        do_apply;
    logic [7:0]  rem_dec;
    logic [7:0]  filled;
    logic [1:0]  type_sel;

    always_comb begin
        n_offset = r_offset;
        n_hgood  = r_hgood;
        n_xid    = r_xid;
        n_magic  = r_magic;
        n_yip    = r_yip;
        n_phase  = r_phase;
        n_code   = r_code;
        n_rem    = r_rem;
        n_len    = r_len;
        n_vbuf   = r_vbuf;
        n_seen   = r_seen;
        n_server = r_server;
        n_mask   = r_mask;
        n_router = r_router;
        n_dns    = r_dns;
        do_apply = 1'b0;
        rem_dec  = r_rem - 8'd1;
        filled   = r_len - r_rem;
        type_sel = 2'd0;
        o_push   = 1'b0;
        o_evt    = '0;

        if (i_accept && !i_opcode) begin
            o_push          = 1'b1;
            o_evt.is_start  = 1'b1;
            o_evt.bind_failed = i_bind_failed;
            o_evt.server    = r_server;
            o_evt.mask      = r_mask;
            o_evt.router    = r_router;
            o_evt.dns       = r_dns;
        end else if (i_accept) begin
            if (r_offset == 8'd0)
                n_hgood = (i_byte == OP_REPLY);
            if (r_offset >= IDX_XID_LO && r_offset <= IDX_XID_HI)
                n_xid = {i_byte, r_xid[31:8]};
            if (r_offset == IDX_XID_HI && n_xid != i_xid)
                n_hgood = 1'b0;
            if (r_offset >= IDX_YIP_LO && r_offset <= IDX_YIP_HI)
                n_yip = {r_yip[23:0], i_byte};
            if (r_offset >= IDX_MAGIC_LO && r_offset <= IDX_LAST_HDR)
                n_magic = {r_magic[23:0], i_byte};
            if (r_offset == IDX_LAST_HDR && n_magic != COOKIE_VALUE)
                n_hgood = 1'b0;

            if (r_offset >= IDX_OPTS && r_hgood) begin
                case (r_phase)
                    PH_CODE: begin
                        if (i_byte == OPT_END) begin
                            n_phase = PH_DONE;
                        end else if (i_byte != OPT_PAD) begin
                            n_code  = i_byte;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_len  = i_byte;
                        n_rem  = i_byte;
                        n_vbuf = '0;
                        // zero-length option never matches any capture rule
                        n_phase = (i_byte == 8'd0) ? PH_CODE : PH_VALUE;
                    end
                    PH_VALUE: begin
                        if (filled < 8'd4)
                            n_vbuf = {r_vbuf[23:0], i_byte};
                        n_rem = rem_dec;
                        if (rem_dec == 8'd0) begin
                            do_apply = 1'b1;
                            n_phase  = PH_CODE;
                        end
                    end
                    default: ;
                endcase
            end

            if (do_apply) begin
                type_sel = (r_len >= 8'd4) ? 2'd3 : r_len[1:0] - 2'd1;
                case (r_code)
                    OPT_MTYPE:   n_seen = n_vbuf[{type_sel, 3'b000} +: 8];
                    OPT_MASK:    if (r_len == 8'd4) n_mask = n_vbuf;
                    OPT_GATEWAY: if (r_len >= 8'd4) n_router = n_vbuf;
                    OPT_DNS:     if (r_len >= 8'd4) n_dns = n_vbuf;
                    OPT_SERVER:  if (r_len == 8'd4) n_server = n_vbuf;
                    default: ;
                endcase
            end

            if (r_offset < IDX_OPTS)
                n_offset = r_offset + 8'd1;

            if (i_last) begin
                o_push         = 1'b1;
                o_evt.reply_ok = (r_offset >= IDX_LAST_HDR) && n_hgood;
                o_evt.mtype    = o_evt.reply_ok ? n_seen : 8'd0;
                o_evt.your_ip  = n_yip;
                o_evt.server   = n_server;
                o_evt.mask     = n_mask;
                o_evt.router   = n_router;
                o_evt.dns      = n_dns;
                // start over for the next packet
                n_offset = '0;
                n_hgood  = 1'b1;
                n_xid    = '0;
                n_magic  = '0;
                n_yip    = '0;
                n_phase  = PH_CODE;
                n_code   = '0;
                n_rem    = '0;
                n_len    = '0;
                n_vbuf   = '0;
                n_seen   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_hgood  <= 1'b1;
            r_xid    <= '0;
            r_magic  <= '0;
            r_yip    <= '0;
            r_phase  <= PH_CODE;
            r_code   <= '0;
            r_rem    <= '0;
            r_len    <= '0;
            r_vbuf   <= '0;
            r_seen   <= '0;
            r_server <= '0;
            r_mask   <= '0;
            r_router <= '0;
            r_dns    <= '0;
        end else begin
            r_offset <= n_offset;
            r_hgood  <= n_hgood;
            r_xid    <= n_xid;
            r_magic  <= n_magic;
            r_yip    <= n_yip;
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_rem    <= n_rem;
            r_len    <= n_len;
            r_vbuf   <= n_vbuf;
            r_seen   <= n_seen;
            r_server <= n_server;
            r_mask   <= n_mask;
            r_router <= n_router;
            r_dns    <= n_dns;
        end
    end

endmodule

@@ src/drp_queue.sv @@
// Two-entry event queue between the parser and the client machine.
module drp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  drp_pkg::t_evt i_evt,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nonempty,
    output drp_pkg::t_evt o_evt
);
    import drp_pkg::*;

    t_evt       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_evt      = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop)
            n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop)
            n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/drp_back.sv @@
// Client state machine and registered result stage.
module drp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_evt_valid,
    input  drp_pkg::t_evt                     i_evt,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [drp_pkg::OUT_DATA_W-1:0]    o_data
);
    import drp_pkg::*;

    t_client_state r_state, n_state;
    t_action       act;
    logic [31:0]   assigned;
    logic          r_valid;
    logic [OUT_DATA_W-1:0] r_data;

    assign o_pop   = i_evt_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // next state
    always_comb begin
        n_state = r_state;
        if (i_evt.is_start) begin
            if (r_state == ST_INIT)
                n_state = i_evt.bind_failed ? ST_FAIL : ST_DISC;
        end else if (i_evt.reply_ok) begin
            case (r_state)
                ST_DISC: if (i_evt.mtype == MT_OFFER) n_state = ST_REQ;
                ST_REQ: begin
                    if (i_evt.mtype == MT_ACK)
                        n_state = ST_BOUND;
                    else if (i_evt.mtype == MT_NAK)
                        n_state = ST_FAIL;
                end
                default: ;
            endcase
        end
    end

    // reported action and address
    always_comb begin
        act      = ACT_NONE;
        assigned = '0;
        if (i_evt.is_start) begin
            if (r_state == ST_INIT)
                act = i_evt.bind_failed ? ACT_BINDFAIL : ACT_DISCOVER;
        end else if (i_evt.reply_ok) begin
            case (r_state)
                ST_DISC: begin
                    if (i_evt.mtype == MT_OFFER) begin
                        act      = ACT_REQUEST;
                        assigned = i_evt.your_ip;
                    end
                end
                ST_REQ: begin
                    if (i_evt.mtype == MT_ACK) begin
                        act      = ACT_BOUND;
                        assigned = i_evt.your_ip;
                    end else if (i_evt.mtype == MT_NAK) begin
                        act = ACT_REJECTED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_data <= {2'b00, i_evt.dns, i_evt.router, i_evt.mask, i_evt.server,
                       assigned, i_evt.mtype, n_state, act};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ tb/dhcp_reply_parser_client_fsm_tb.sv @@
// Self-checking bench for the DHCP reply parser and client state machine.
module dhcp_reply_parser_client_fsm_tb;
    import drp_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       is_byte;
        logic       bind_failed;
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]    fill;
        logic [31:0]   dns;
        logic [31:0]   router;
        logic [31:0]   mask;
        logic [31:0]   server;
        logic [31:0]   assigned;
        logic [7:0]    mtype;
        t_client_state state;
        t_action       action;
    } dhcp_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;   // port_bind_failed, payload_byte[8:1]
    logic                  i_s_tuser = 1'b0; // opcode
    logic                  i_s_tlast = 1'b0; // last_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // action, client_state, message_type, assigned_ip, server, mask, router, dns
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [1:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    dhcp_reply_parser_client_fsm DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    rx_item_t     rx_queue[$];
    dhcp_result_t want_results[$];
    logic [7:0]   pkt[$];
    rx_item_t     cur_req = '0;
    int unsigned  failures = 0;
    int unsigned  src_gap = 0;
    int unsigned  sink_gap = 0;
    int unsigned  hold_left = 0;
    int unsigned  stall_asks = 0;
    int unsigned  stall_done = 0;
    int unsigned  stuck_cycles = 0;
    bit           no_idling = 1'b0;

    // client model state
    logic [31:0]   xid_cfg;
    t_client_state cl_state;
    logic [7:0]    byte_pos;
    logic          hdr_ok;
    logic [31:0]   xid_acc;
    logic [31:0]   cookie_acc;
    logic [31:0]   yiaddr;
    t_opt_phase    opt_ph;
    logic [7:0]    opt_code;
    logic [7:0]    opt_left;
    logic [7:0]    opt_len;
    logic [31:0]   opt_val;
    logic [7:0]    seen_mtype;
    logic [31:0]   offered;
    logic [31:0]   srv_store;
    logic [31:0]   mask_store;
    logic [31:0]   gw_store;
    logic [31:0]   dns_store;

    function automatic void clear_parser();
        byte_pos   = '0;
        hdr_ok     = 1'b1;
        xid_acc    = '0;
        cookie_acc = '0;
        yiaddr     = '0;
        opt_ph     = PH_CODE;
        opt_code   = '0;
        opt_left   = '0;
        opt_len    = '0;
        opt_val    = '0;
        seen_mtype = '0;
    endfunction

    function automatic void take_option();
        int sh;
        sh = (opt_len >= 8'd4) ? 24 : 8 * (int'(opt_len) - 1);
        case (opt_code)
            OPT_MTYPE:   if (opt_len != 8'd0) seen_mtype = 8'(opt_val >> sh);
            OPT_MASK:    if (opt_len == 8'd4) mask_store = opt_val;
            OPT_GATEWAY: if (opt_len >= 8'd4) gw_store = opt_val;
            OPT_DNS:     if (opt_len >= 8'd4) dns_store = opt_val;
            OPT_SERVER:  if (opt_len == 8'd4) srv_store = opt_val;
            default: ;
        endcase
    endfunction

    // Advance the client model by one accepted request and queue its result, if any.
    task automatic predict_client(input rx_item_t it);
        dhcp_result_t r;
        logic [7:0]   b;
        logic [7:0]   idx;
        r = '0;
        if (!it.is_byte) begin
            if (cl_state == ST_INIT) begin
                if (it.bind_failed) begin
                    cl_state = ST_FAIL;
                    r.action = ACT_BINDFAIL;
                end else begin
                    cl_state = ST_DISC;
                    r.action = ACT_DISCOVER;
                end
            end
        end else begin
            b = it.data;
            idx = byte_pos;
            if (idx == 8'd0) hdr_ok = (b == OP_REPLY);
            if (idx >= IDX_XID_LO && idx <= IDX_XID_HI) xid_acc = {b, xid_acc[31:8]};
            if (idx == IDX_XID_HI && xid_acc != xid_cfg) hdr_ok = 1'b0;
            if (idx >= IDX_YIP_LO && idx <= IDX_YIP_HI) yiaddr = {yiaddr[23:0], b};
            if (idx >= IDX_MAGIC_LO && idx <= IDX_LAST_HDR) cookie_acc = {cookie_acc[23:0], b};
            if (idx == IDX_LAST_HDR && cookie_acc != COOKIE_VALUE) hdr_ok = 1'b0;
            if (idx >= IDX_OPTS && hdr_ok) begin
                case (opt_ph)
                    PH_CODE: begin
                        if (b == OPT_END) begin
                            opt_ph = PH_DONE;
                        end else if (b != OPT_PAD) begin
                            opt_code = b;
                            opt_ph = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        opt_len = b;
                        opt_left = b;
                        opt_val = '0;
                        if (b == 8'd0) begin
                            take_option();
                            opt_ph = PH_CODE;
                        end else begin
                            opt_ph = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        // only the first four value bytes are kept
                        if (opt_len - opt_left < 8'd4) opt_val = {opt_val[23:0], b};
                        opt_left = opt_left - 8'd1;
                        if (opt_left == 8'd0) begin
                            take_option();
                            opt_ph = PH_CODE;
                        end
                    end
                    default: ;
                endcase
            end
            if (byte_pos < IDX_OPTS) byte_pos = byte_pos + 8'd1;
            if (!it.last) return;
            if (idx >= IDX_LAST_HDR && hdr_ok) begin
                r.mtype = seen_mtype;
                if (cl_state == ST_DISC && seen_mtype == MT_OFFER) begin
                    offered = yiaddr;
                    cl_state = ST_REQ;
                    r.action = ACT_REQUEST;
                    r.assigned = offered;
                end else if (cl_state == ST_REQ && seen_mtype == MT_ACK) begin
                    cl_state = ST_BOUND;
                    r.action = ACT_BOUND;
                    r.assigned = yiaddr;
                end else if (cl_state == ST_REQ && seen_mtype == MT_NAK) begin
                    cl_state = ST_FAIL;
                    r.action = ACT_REJECTED;
                end
            end
            clear_parser();
        end
        r.state  = cl_state;
        r.server = srv_store;
        r.mask   = mask_store;
        r.router = gw_store;
        r.dns    = dns_store;
        want_results.push_back(r);
    endtask

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------- stimulus builders ----------------

    task automatic push_start(input bit bind_failed);
        rx_item_t it;
        it.is_byte = 1'b0;
        it.bind_failed = bind_failed;
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        rx_queue.push_back(it);
    endtask

    task automatic begin_reply(input logic [7:0] op, input logic [31:0] xid,
                               input logic [31:0] yip, input logic [31:0] cookie);
        pkt.delete();
        repeat (240) pkt.push_back(8'($urandom));
        pkt[0] = op;
        for (int k = 0; k < 4; k++) begin
            pkt[4 + k]   = xid[8*k +: 8];
            pkt[16 + k]  = yip[31 - 8*k -: 8];
            pkt[236 + k] = cookie[31 - 8*k -: 8];
        end
    endtask

    // value bytes beyond the fourth are random filler
    task automatic add_opt(input logic [7:0] code, input logic [7:0] len, input logic [31:0] val);
        pkt.push_back(code);
        pkt.push_back(len);
        for (int k = 0; k < int'(len); k++)
            pkt.push_back((k < 4) ? val[31 - 8*k -: 8] : 8'($urandom));
    endtask

    task automatic send_pkt(input bit mid_start);
        rx_item_t it;
        int cut;
        cut = mid_start ? $urandom_range(0, pkt.size() - 1) : -1;
        foreach (pkt[k]) begin
            if (k == cut) push_start(1'($urandom));
            it.is_byte = 1'b1;
            it.bind_failed = 1'($urandom);
            it.data = pkt[k];
            it.last = (k == pkt.size() - 1);
            rx_queue.push_back(it);
        end
    endtask

    // Full-length ack or nak, sometimes with a bad header, ending in a cut-off option.
    task automatic random_reply();
        int flaw;
        int len;
        logic [7:0]  op;
        logic [7:0]  mt;
        logic [31:0] xid;
        logic [31:0] cookie;
        flaw = $urandom_range(0, 5);
        op = OP_REPLY;
        xid = xid_cfg;
        cookie = COOKIE_VALUE;
        if (flaw == 0) op = 8'($urandom);
        if (flaw == 1) xid ^= 32'd1 << $urandom_range(0, 31);
        if (flaw == 2) cookie ^= 32'd1 << $urandom_range(0, 31);
        mt = ($urandom_range(0, 3) == 0) ? MT_NAK : MT_ACK;
        begin_reply(op, xid, $urandom, cookie);
        add_opt(OPT_DNS, 8'($urandom_range(3, 8)), $urandom);
        add_opt(OPT_MASK, 8'($urandom_range(3, 5)), $urandom);
        pkt.push_back(OPT_PAD);
        add_opt(OPT_MTYPE, 8'd1, {mt, 24'($urandom)});
        // option cut off by the packet end
        len = $urandom_range(1, 9);
        pkt.push_back(($urandom_range(0, 1) == 1) ? OPT_MTYPE : OPT_SERVER);
        pkt.push_back(8'(len));
        repeat ($urandom_range(0, len - 1)) pkt.push_back(8'($urandom));
        send_pkt(1'b0);
    endtask

    // Packet shorter than a header, sometimes with a start in the middle.
    task automatic random_short();
        pkt.delete();
        repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) pkt[0] = OP_REPLY;
        send_pkt($urandom_range(0, 3) == 0);
    endtask

    task automatic directed_replies();
        // single-byte packet
        pkt.delete();
        pkt.push_back(OP_REPLY);
        send_pkt(1'b0);
        push_start(1'b0);
        push_start(1'b1);
        // offer with every option, a zero-length one, a pad, bytes after the end
        // option; long enough for the offset to saturate
        begin_reply(OP_REPLY, xid_cfg, 32'hC0A8_0164, COOKIE_VALUE);
        pkt.push_back(OPT_PAD);
        add_opt(OPT_MASK, 8'd4, 32'hFFFF_FF00);
        add_opt(OPT_GATEWAY, 8'd8, 32'h0A00_0001);
        add_opt(OPT_DNS, 8'd4, 32'h0808_0404);
        add_opt(OPT_SERVER, 8'd4, 32'hFFFF_FFFF);
        add_opt(OPT_MTYPE, 8'd3, {MT_OFFER, 24'h07_0000});
        add_opt(OPT_SERVER, 8'd0, '0);
        add_opt(8'd200, 8'd6, $urandom);
        pkt.push_back(OPT_END);
        add_opt(OPT_MTYPE, 8'd1, {MT_NAK, 24'h0});
        add_opt(OPT_MASK, 8'd4, 32'h0);
        send_pkt(1'b1);
    endtask

    // Wait until everything sent has been answered and the pipeline has drained.
    task automatic settle();
        do @(negedge i_clk);
        while (rx_queue.size() != 0 || i_s_tvalid || want_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [31:0] value);
        logic [31:0] got;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_XID;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        xid_cfg = value;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== xid_cfg)
            note_failure($sformatf("xid readback: expected %h got %h", xid_cfg, got));
        @(negedge i_clk);
    endtask

    // ---------------- request driver ----------------

    always @(posedge i_clk) begin : request_driver
        logic offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            offer = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                predict_client(cur_req);
                offer = 1'b0;
            end
            if (!offer) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (rx_queue.size() != 0) begin
                    cur_req = rx_queue.pop_front();
                    offer = 1'b1;
                    if (!no_idling && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 19);
                end
            end
            i_s_tvalid <= offer;
            i_s_tdata <= {7'b0, cur_req.data, cur_req.bind_failed};
            i_s_tuser <= cur_req.is_byte;
            i_s_tlast <= cur_req.last;
        end
    end

    // ---------------- result sink ----------------

    always @(posedge i_clk) begin : result_sink
        logic rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            rdy = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_asks != stall_done) begin
                stall_done++;
                hold_left = HOLD_CYCLES;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else begin
                rdy = 1'b1;
                if (!no_idling && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 19);
            end
            i_m_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        dhcp_result_t got;
        dhcp_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (want_results.size() == 0) begin
                note_failure($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                want = want_results.pop_front();
                if (got !== want)
                    note_failure($sformatf({"result mismatch (exp/got): action %0d/%0d ",
                        "state %0d/%0d mtype %0d/%0d ip %h/%h srv %h/%h ",
                        "mask %h/%h gw %h/%h dns %h/%h fill %b/%b"},
                        want.action, got.action, want.state, got.state,
                        want.mtype, got.mtype, want.assigned, got.assigned,
                        want.server, got.server, want.mask, got.mask,
                        want.router, got.router, want.dns, got.dns, want.fill, got.fill));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin : main_sequence
        logic [31:0] xid_plan[2];
        xid_cfg    = XID_RESET;
        cl_state   = ST_INIT;
        offered    = '0;
        srv_store  = '0;
        mask_store = '0;
        gw_store   = '0;
        dns_store  = '0;
        clear_parser();
        xid_plan[0] = $urandom;
        xid_plan[1] = XID_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // discover and offer on the reset xid
        directed_replies();
        settle();
        cfg_write(xid_plan[0]);
        // sink holds off while a burst of starts backs up the block
        stall_asks++;
        repeat (40) push_start(1'($urandom));
        random_reply();
        settle();
        cfg_write(xid_plan[1]);
        no_idling = 1'b1;
        repeat (14) begin
            if ($urandom_range(0, 3) == 0) push_start(1'($urandom));
            random_short();
        end
        settle();
        repeat (6) @(negedge i_clk);
        if (failures == 0 && want_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/drp_pkg.sv
src/drp_front.sv
src/drp_queue.sv
src/drp_back.sv
src/dhcp_reply_parser_client_fsm.sv
tb/dhcp_reply_parser_client_fsm_tb.sv
